### hw/rtl/poil_pkg.sv
// Package for the positional insert ordered list.
// Holds store sizing, action and status codes. No dependencies.
package poil_pkg;

  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = AW + 1;

  localparam int ACT_W  = 2;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 7;
  localparam int STAT_W = 2;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_POS   = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] cnt_t;

endpackage

### hw/rtl/poil_if.sv
// Valid/ready channel interfaces for the positional insert ordered list.
// Depends on poil_pkg for field widths.
interface poil_in_if;
  logic                                valid;
  logic                                ready;
  logic [poil_pkg::ACT_W-1:0]          action;
  logic signed [poil_pkg::VAL_W-1:0]   item_value;
  logic [poil_pkg::POS_W-1:0]          position;

  modport source (output valid, action, item_value, position, input ready);
  modport sink   (input valid, action, item_value, position, output ready);
endinterface

interface poil_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [poil_pkg::VAL_W-1:0]   read_value;
  logic [poil_pkg::STAT_W-1:0]         status;
  logic [poil_pkg::POS_W-1:0]          entry_count;

  modport source (output valid, read_value, status, entry_count, input ready);
  modport sink   (input valid, read_value, status, entry_count, output ready);
endinterface

### hw/rtl/positional_insert_ordered_list_top.sv
// Positional insert ordered list, top level.
// Depends on poil_pkg and the poil_in_if / poil_out_if channel interfaces.
//
// Ordered list of up to 64 signed 32-bit entries kept in a ring store, one
// request at a time, one result per request. The store is a single-port-write,
// registered-read memory, and every entry visited takes a read state, then a
// use state. Bad-position, full and unused actions answer from idle. Insert
// at position p moves m entries, m = p if 2p <= count, else count - p.
// Remove searches from the front to the first match at position i, then moves
// m entries, m = i if 2i < count, else count - 1 - i; a miss searches all
// entries. Input ready is high only while idle with no result held.
module positional_insert_ordered_list_top (
  input  logic              clk,
  input  logic              rst_n,
  poil_in_if.sink           in_ch,
  poil_out_if.source        out_ch
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SRCH_RD  = 3'd1;
  localparam logic [2:0] S_SRCH_CMP = 3'd2;
  localparam logic [2:0] S_MV_RD    = 3'd3;
  localparam logic [2:0] S_MV_WR    = 3'd4;
  localparam logic [2:0] S_RD_OUT   = 3'd5;

  logic [2:0]                        state_r, state_nxt;
  poil_pkg::cnt_t                    idx_r, idx_nxt;
  poil_pkg::cnt_t                    lim_r, lim_nxt;
  logic                              up_r, up_nxt;
  logic                              ffix_r, ffix_nxt;
  logic [poil_pkg::ACT_W-1:0]        op_r, op_nxt;
  logic [poil_pkg::VAL_W-1:0]        val_r, val_nxt;
  logic [poil_pkg::POS_W-1:0]        pos_r, pos_nxt;
  poil_pkg::addr_t                   front_r, front_nxt;
  poil_pkg::cnt_t                    cnt_r, cnt_nxt;
  logic                              ovld_r, ovld_nxt;
  logic [poil_pkg::VAL_W-1:0]        ord_r, ord_nxt;
  logic [poil_pkg::STAT_W-1:0]       ost_r, ost_nxt;

  logic [poil_pkg::VAL_W-1:0]        mem [poil_pkg::DEPTH];
  logic [poil_pkg::VAL_W-1:0]        rdata_r;
  poil_pkg::addr_t                   raddr, waddr;
  logic [poil_pkg::VAL_W-1:0]        wdata;
  logic                              we;
  logic                              in_ready;
  poil_pkg::addr_t                   cur_addr;

  assign in_ready     = (state_r == S_IDLE) && !ovld_r;
  assign in_ch.ready  = in_ready;
  assign out_ch.valid       = ovld_r;
  assign out_ch.read_value  = ord_r;
  assign out_ch.status      = ost_r;
  assign out_ch.entry_count = cnt_r;
  assign cur_addr = poil_pkg::AW'(front_r + idx_r[poil_pkg::AW-1:0]);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    lim_nxt   = lim_r;
    up_nxt    = up_r;
    ffix_nxt  = ffix_r;
    op_nxt    = op_r;
    val_nxt   = val_r;
    pos_nxt   = pos_r;
    front_nxt = front_r;
    cnt_nxt   = cnt_r;
    ovld_nxt  = ovld_r;
    ord_nxt   = ord_r;
    ost_nxt   = ost_r;
    we        = 1'b0;
    waddr     = cur_addr;
    wdata     = val_r;
    raddr     = cur_addr;
    if (ovld_r && out_ch.ready) begin
      ovld_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid && in_ready) begin
          op_nxt   = in_ch.action;
          val_nxt  = in_ch.item_value;
          pos_nxt  = in_ch.position;
          ffix_nxt = 1'b0;
          ord_nxt  = '0;
          case (in_ch.action)
            poil_pkg::ACT_INSERT: begin
              if (in_ch.position > cnt_r) begin
                ovld_nxt = 1'b1;
                ost_nxt  = poil_pkg::ST_BAD_POS;
              end else if (cnt_r == poil_pkg::CW'(poil_pkg::DEPTH)) begin
                ovld_nxt = 1'b1;
                ost_nxt  = poil_pkg::ST_FULL;
              end else if ({in_ch.position, 1'b0} <= {1'b0, cnt_r}) begin
                front_nxt = poil_pkg::AW'(front_r - poil_pkg::AW'(1));
                idx_nxt   = '0;
                lim_nxt   = in_ch.position;
                up_nxt    = 1'b1;
                state_nxt = S_MV_RD;
              end else begin
                idx_nxt   = cnt_r;
                lim_nxt   = in_ch.position;
                up_nxt    = 1'b0;
                state_nxt = S_MV_RD;
              end
            end
            poil_pkg::ACT_REMOVE: begin
              idx_nxt   = '0;
              state_nxt = S_SRCH_RD;
            end
            poil_pkg::ACT_READ: begin
              if (in_ch.position >= cnt_r) begin
                ovld_nxt = 1'b1;
                ost_nxt  = poil_pkg::ST_BAD_POS;
              end else begin
                raddr     = poil_pkg::AW'(front_r + in_ch.position[poil_pkg::AW-1:0]);
                state_nxt = S_RD_OUT;
              end
            end
            default: begin
              ovld_nxt = 1'b1;
              ost_nxt  = poil_pkg::ST_OK;
            end
          endcase
        end
      end
      S_SRCH_RD: begin
        if (idx_r == cnt_r) begin
          ovld_nxt  = 1'b1;
          ost_nxt   = poil_pkg::ST_NOT_FOUND;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (rdata_r == val_r) begin
          state_nxt = S_MV_RD;
          if ({idx_r, 1'b0} < {1'b0, cnt_r}) begin
            up_nxt   = 1'b0;
            lim_nxt  = '0;
            ffix_nxt = 1'b1;
          end else begin
            up_nxt   = 1'b1;
            lim_nxt  = poil_pkg::CW'(cnt_r - poil_pkg::CW'(1));
            ffix_nxt = 1'b0;
          end
        end else begin
          idx_nxt   = poil_pkg::CW'(idx_r + poil_pkg::CW'(1));
          state_nxt = S_SRCH_RD;
        end
      end
      S_MV_RD: begin
        if (idx_r == lim_r) begin
          ovld_nxt  = 1'b1;
          ost_nxt   = poil_pkg::ST_OK;
          state_nxt = S_IDLE;
          if (op_r == poil_pkg::ACT_INSERT) begin
            we      = 1'b1;
            waddr   = poil_pkg::AW'(front_r + pos_r[poil_pkg::AW-1:0]);
            wdata   = val_r;
            cnt_nxt = poil_pkg::CW'(cnt_r + poil_pkg::CW'(1));
          end else begin
            cnt_nxt = poil_pkg::CW'(cnt_r - poil_pkg::CW'(1));
            if (ffix_r) begin
              front_nxt = poil_pkg::AW'(front_r + poil_pkg::AW'(1));
            end
          end
        end else begin
          raddr     = up_r ? poil_pkg::AW'(cur_addr + poil_pkg::AW'(1))
                           : poil_pkg::AW'(cur_addr - poil_pkg::AW'(1));
          state_nxt = S_MV_WR;
        end
      end
      S_MV_WR: begin
        we        = 1'b1;
        waddr     = cur_addr;
        wdata     = rdata_r;
        idx_nxt   = up_r ? poil_pkg::CW'(idx_r + poil_pkg::CW'(1))
                         : poil_pkg::CW'(idx_r - poil_pkg::CW'(1));
        state_nxt = S_MV_RD;
      end
      S_RD_OUT: begin
        ovld_nxt  = 1'b1;
        ost_nxt   = poil_pkg::ST_OK;
        ord_nxt   = rdata_r;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      front_r <= poil_pkg::AW'(poil_pkg::DEPTH / 2);
      cnt_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      cnt_r   <= cnt_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    lim_r  <= lim_nxt;
    up_r   <= up_nxt;
    ffix_r <= ffix_nxt;
    op_r   <= op_nxt;
    val_r  <= val_nxt;
    pos_r  <= pos_nxt;
    ord_r  <= ord_nxt;
    ost_r  <= ost_nxt;
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= poil_pkg::CW'(poil_pkg::DEPTH))
    else $error("entry count above store depth");

  a_cnt_only_at_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> ($rose(ovld_r) && state_r == S_IDLE))
    else $error("entry count changed without a result");

  a_result_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovld_r) |-> (state_r == S_IDLE))
    else $error("result raised while sequencer busy");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(ovld_r) && ost_r == poil_pkg::ST_FULL) |->
      (cnt_r == poil_pkg::CW'(poil_pkg::DEPTH)))
    else $error("full status with room left");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !we)
    else $error("store written while idle");
`endif

endmodule

### test/testbench.sv
// Testbench for positional_insert_ordered_list_top: directed then random list requests,
// random stalls on both channels, every result checked against an in-bench list model.
// Depends on poil_pkg, poil_in_if / poil_out_if and the top level.
module testbench;

  typedef struct packed {
    logic [poil_pkg::ACT_W-1:0]        act;
    logic signed [poil_pkg::VAL_W-1:0] val;
    logic [poil_pkg::POS_W-1:0]        pos;
  } request_t;

  typedef struct packed {
    logic signed [poil_pkg::VAL_W-1:0] rd;
    logic [poil_pkg::STAT_W-1:0]       st;
    logic [poil_pkg::POS_W-1:0]        cnt;
  } response_t;

  localparam logic [poil_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

  localparam int BATCH      = 24;
  localparam int RANDOM_REQ = 1150;
  localparam int HOLD_AT    = 300;
  localparam int HOLD_LEN   = 400;
  localparam int DRAIN_WAIT = 250;
  localparam int MAX_PRINTS = 100;

  logic clk;
  logic rst_n;

  poil_in_if  in_ch();
  poil_out_if out_ch();

  positional_insert_ordered_list_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // list model: ring store, slot of the front entry, entries held
  logic signed [poil_pkg::VAL_W-1:0] ring [poil_pkg::DEPTH];
  poil_pkg::addr_t head_slot = poil_pkg::addr_t'(poil_pkg::DEPTH / 2);
  poil_pkg::cnt_t  list_len  = '0;

  request_t  pending_requests [$];
  response_t expected_results [$];

  int error_count  = 0;
  int results_seen = 0;
  int send_gap     = 0;
  int ready_gap    = 0;
  int hold_cycles  = 0;
  bit hold_done    = 1'b0;
  bit idle_enabled = 1'b1;

  function automatic poil_pkg::addr_t slot(int p);
    return poil_pkg::addr_t'(head_slot + p);
  endfunction

  function automatic response_t apply_to_list(request_t r);
    response_t res;
    int p, n, i, k;
    bit hit;
    res = '0;
    p = int'(r.pos);
    n = int'(list_len);
    i = 0;
    hit = 1'b0;
    case (r.act)
      poil_pkg::ACT_INSERT: begin
        if (p > n) begin
          res.st = poil_pkg::ST_BAD_POS;
        end else if (n == poil_pkg::DEPTH) begin
          res.st = poil_pkg::ST_FULL;
        end else begin
          if (2 * p <= n) begin
            head_slot = head_slot - 1'b1;
            for (k = 0; k < p; k++) ring[slot(k)] = ring[slot(k + 1)];
          end else begin
            for (k = n; k > p; k--) ring[slot(k)] = ring[slot(k - 1)];
          end
          ring[slot(p)] = r.val;
          list_len = list_len + 1'b1;
        end
      end
      poil_pkg::ACT_REMOVE: begin
        for (k = 0; k < n && !hit; k++) begin
          if (ring[slot(k)] == r.val) begin
            hit = 1'b1;
            i = k;
          end
        end
        if (!hit) begin
          res.st = poil_pkg::ST_NOT_FOUND;
        end else begin
          if (2 * i < n) begin
            for (k = i; k > 0; k--) ring[slot(k)] = ring[slot(k - 1)];
            head_slot = head_slot + 1'b1;
          end else begin
            for (k = i; k + 1 < n; k++) ring[slot(k)] = ring[slot(k + 1)];
          end
          list_len = list_len - 1'b1;
        end
      end
      poil_pkg::ACT_READ: begin
        if (p >= n) res.st = poil_pkg::ST_BAD_POS;
        else res.rd = ring[slot(p)];
      end
      default: ;
    endcase
    res.cnt = list_len;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("result %0d: %s", results_seen, msg);
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [poil_pkg::VAL_W-1:0] pool_value(int k);
    case (k)
      0: return '0;
      1: return -32'sd1;
      2: return 32'sd1;
      3: return 32'sh8000_0000;
      4: return 32'sh7FFF_FFFF;
      5: return 32'sh5555_5555;
      6: return 32'shAAAA_AAAA;
      default: return 32'sd7;
    endcase
  endfunction

  // a small pool makes duplicates and remove hits common
  function automatic logic signed [poil_pkg::VAL_W-1:0] pick_value();
    if ($urandom_range(0, 9) < 4) return pool_value($urandom_range(0, 7));
    return $urandom;
  endfunction

  function automatic logic [poil_pkg::POS_W-1:0] pick_position(int lim);
    int c;
    c = $urandom_range(0, 19);
    if (c == 0) return poil_pkg::POS_W'($urandom_range(0, 127));
    if (c == 1) return poil_pkg::POS_W'(lim + 1);
    return poil_pkg::POS_W'($urandom_range(0, lim));
  endfunction

  task automatic queue_request(logic [poil_pkg::ACT_W-1:0] a,
                               logic signed [poil_pkg::VAL_W-1:0] v,
                               logic [poil_pkg::POS_W-1:0] p);
    request_t r;
    r.act = a;
    r.val = v;
    r.pos = p;
    pending_requests.push_back(r);
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin : driver
    request_t r;
    if (!rst_n) begin
      in_ch.valid      <= 1'b0;
      in_ch.action     <= poil_pkg::ACT_INSERT;
      in_ch.item_value <= '0;
      in_ch.position   <= '0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        r.act = in_ch.action;
        r.val = in_ch.item_value;
        r.pos = in_ch.position;
        expected_results.push_back(apply_to_list(r));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          r = pending_requests.pop_front();
          in_ch.action     <= r.act;
          in_ch.item_value <= r.val;
          in_ch.position   <= r.pos;
          in_ch.valid      <= 1'b1;
          send_gap = (idle_enabled && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    response_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      ready_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = expected_results.pop_front();
          if (out_ch.read_value !== want.rd)
            report_mismatch($sformatf("read_value %0d, expected %0d",
                                      out_ch.read_value, want.rd));
          if (out_ch.status !== want.st)
            report_mismatch($sformatf("status %0d, expected %0d", out_ch.status, want.st));
          if (out_ch.entry_count !== want.cnt)
            report_mismatch($sformatf("entry_count %0d, expected %0d",
                                      out_ch.entry_count, want.cnt));
        end
        results_seen++;
      end
      if (ready_gap != 0) ready_gap--;
      else if (idle_enabled && $urandom_range(0, 3) == 0) ready_gap = pick_gap();
      out_ch.ready <= (ready_gap == 0) && (hold_cycles == 0);
    end
  end

  // one long receiver hold-off so the block backs up into the input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cycles <= 0;
      hold_done   <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_cycles <= HOLD_LEN;
      hold_done   <= 1'b1;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  initial begin : stimulus
    int est, n_random, mode, c, ins_pct, rem_pct, k;
    logic [poil_pkg::ACT_W-1:0] a;
    logic signed [poil_pkg::VAL_W-1:0] v;
    logic [poil_pkg::POS_W-1:0] p;

    rst_n = 1'b0;

    // empty list, bad positions, both insert sides, duplicates, reads, removes
    queue_request(poil_pkg::ACT_REMOVE, 32'sd5, '0);
    queue_request(poil_pkg::ACT_READ, '0, '0);
    queue_request(poil_pkg::ACT_INSERT, 32'sd9, 7'd1);
    queue_request(poil_pkg::ACT_INSERT, 32'sd9, 7'd127);
    queue_request(poil_pkg::ACT_INSERT, 32'sh7FFF_FFFF, 7'd0);
    queue_request(poil_pkg::ACT_INSERT, 32'sh8000_0000, 7'd1);
    queue_request(poil_pkg::ACT_INSERT, '0, 7'd0);
    queue_request(poil_pkg::ACT_INSERT, -32'sd1, 7'd3);
    queue_request(poil_pkg::ACT_INSERT, 32'sh5555_5555, 7'd2);
    queue_request(poil_pkg::ACT_INSERT, 32'sh5555_5555, 7'd5);
    for (k = 0; k < 7; k++) queue_request(poil_pkg::ACT_READ, '0, poil_pkg::POS_W'(k));
    queue_request(ACT_UNUSED, -32'sd1, 7'd127);
    queue_request(poil_pkg::ACT_REMOVE, 32'sh5555_5555, '0);
    queue_request(poil_pkg::ACT_REMOVE, 32'sh8000_0000, '0);
    queue_request(poil_pkg::ACT_REMOVE, -32'sd1, '0);
    queue_request(poil_pkg::ACT_REMOVE, '0, '0);
    queue_request(poil_pkg::ACT_READ, '0, 7'd64);
    queue_request(poil_pkg::ACT_REMOVE, 32'sd12345, '0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    n_random = 0;
    mode = 0;
    while (n_random < RANDOM_REQ) begin
      wait_drained();
      idle_enabled = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: begin ins_pct = 80; rem_pct = 8;  end
        1: begin ins_pct = 15; rem_pct = 70; end
        default: begin ins_pct = 40; rem_pct = 40; end
      endcase
      est = int'(list_len);
      repeat (BATCH) begin
        c = $urandom_range(0, 99);
        if (c < 3) a = ACT_UNUSED;
        else if (c < 3 + ins_pct) a = poil_pkg::ACT_INSERT;
        else if (c < 3 + ins_pct + rem_pct) a = poil_pkg::ACT_REMOVE;
        else a = poil_pkg::ACT_READ;
        v = pick_value();
        p = pick_position(est);
        case (a)
          poil_pkg::ACT_INSERT: begin
            if (p <= est && est < poil_pkg::DEPTH) est++;
          end
          poil_pkg::ACT_REMOVE: begin
            if (list_len != 0 && $urandom_range(0, 4) != 0)
              v = ring[slot($urandom_range(0, int'(list_len) - 1))];
            if (est > 0) est--;
          end
          poil_pkg::ACT_READ: begin
            if (est > 0 && $urandom_range(0, 7) != 0)
              p = poil_pkg::POS_W'($urandom_range(0, est - 1));
          end
          default: ;
        endcase
        queue_request(a, v, p);
        if (a != ACT_UNUSED) n_random++;
      end
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
